// File: rtl/prq_pkg.sv
// Shared constants, codes and types for the policy-ordered ready queue.
// No dependencies; prq_cmp, prq_ctrl and the top level import this package.
`default_nettype none

package prq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int LEVEL_COUNT_DEF = 3;

	localparam int TAG_W    = 8;
	localparam int BURST_W  = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	// policy register codes
	localparam logic [MODE_W-1:0] MODE_FCFS            = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SJF             = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIORITY        = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RANDOM_PRIORITY = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// finished-transaction report from the sequencer to the output stage
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
	} prq_done_t;

endpackage

`default_nettype wire

// File: rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/prq_cmp.sv
// Placement comparator: tells whether a new task goes before a stored entry.
// Depends on prq_pkg for the policy codes and field widths.
`default_nettype none

module prq_cmp #(
	parameter int LEVEL_W = 2
) (
	input  wire logic [prq_pkg::MODE_W-1:0]  mode,
	input  wire logic [prq_pkg::BURST_W-1:0] ent_burst,
	input  wire logic [LEVEL_W-1:0]          ent_level,
	input  wire logic [prq_pkg::BURST_W-1:0] new_burst,
	input  wire logic [LEVEL_W-1:0]          new_level,
	output logic                             hit
);

	import prq_pkg::*;

	always_comb begin
		// SJF: first entry with burst >= new; priority: first entry of lower level
		if (mode == MODE_SJF) begin
			hit = (ent_burst >= new_burst);
		end else begin
			hit = (ent_level < new_level);
		end
	end

endmodule

`default_nettype wire

// File: rtl/prq_ctrl.sv
// Sequencer of the ready queue: circular slot buffer, ordered scan and shift.
// Depends on prq_pkg and instantiates prq_cmp; drives the slot RAM ports.
`default_nettype none

module prq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int LEVEL_COUNT = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [prq_pkg::MODE_W-1:0]          mode,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                action,
	input  wire logic [prq_pkg::TAG_W-1:0]           task_tag,
	input  wire logic [prq_pkg::BURST_W-1:0]         burst_time,
	input  wire logic [$clog2(LEVEL_COUNT)-1:0]      priority_level,
	output logic                                     ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_waddr,
	output logic [prq_pkg::TAG_W+prq_pkg::BURST_W+$clog2(LEVEL_COUNT)-1:0] ram_wdata,
	output logic                                     ram_re,
	output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_raddr,
	input  wire logic [prq_pkg::TAG_W+prq_pkg::BURST_W+$clog2(LEVEL_COUNT)-1:0] ram_rdata,
	output prq_pkg::prq_done_t                       done,
	input  wire logic                                take,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]         count
);

	import prq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = $clog2(LEVEL_COUNT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_HREAD = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       pos_q;
	logic                pend_q;
	logic [STATUS_W-1:0] status_q;
	logic [TAG_W-1:0]    tag_q;
	logic [BURST_W-1:0]  burst_q;
	logic [LW-1:0]       level_q;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_m2;
	logic [AW-1:0] addr_idx;
	logic [AW-1:0] addr_m1;
	logic [AW-1:0] addr_m2;
	logic [AW-1:0] addr_pos;
	logic [AW-1:0] head_next;
	logic          hit;
	logic          sorted;
	logic          scan_hit;
	logic          scan_end;
	logic          shift_last;

	// logical slot index to physical address, offset at most the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW + 1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign idx_m1    = idx_q - CW'(1);
	assign idx_m2    = idx_q - CW'(2);
	assign addr_idx  = wrap_add(head_q, idx_q);
	assign addr_m1   = wrap_add(head_q, idx_m1);
	assign addr_m2   = wrap_add(head_q, idx_m2);
	assign addr_pos  = wrap_add(head_q, pos_q);
	assign head_next = wrap_add(head_q, CW'(1));

	prq_cmp #(
		.LEVEL_W(LW)
	) u_cmp (
		.mode     (mode),
		.ent_burst(ram_rdata[LW +: BURST_W]),
		.ent_level(ram_rdata[LW-1:0]),
		.new_burst(burst_q),
		.new_level(level_q),
		.hit      (hit)
	);

	always_comb begin
		unique case (mode)
			MODE_SJF, MODE_PRIORITY:         sorted = 1'b1;
			MODE_FCFS, MODE_RANDOM_PRIORITY: sorted = 1'b0;
			default:                         sorted = 1'b0;
		endcase
	end

	// rdata holds slot idx_q-1 whenever pend_q is set
	assign scan_hit   = pend_q && hit;
	assign scan_end   = (idx_q == count_q);
	assign shift_last = (idx_m1 == pos_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_idx;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = addr_idx;
		unique case (state_q)
			S_SCAN: begin
				if (!scan_hit && !scan_end) begin
					ram_re = 1'b1;
				end
			end
			S_SHIFT: begin
				if (!pend_q) begin
					ram_re    = 1'b1;
					ram_raddr = addr_m1;
				end else begin
					// move slot idx-1 up to idx and fetch the next one down
					ram_we = 1'b1;
					if (!shift_last) begin
						ram_re    = 1'b1;
						ram_raddr = addr_m2;
					end
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = addr_pos;
				ram_wdata = {tag_q, burst_q, level_q};
			end
			S_HREAD: begin
				ram_re    = 1'b1;
				ram_raddr = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			pend_q   <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						pos_q  <= count_q;
						if (action == ACT_REMOVE) begin
							state_q <= S_HREAD;
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								status_q <= ST_DONE;
								head_q   <= head_next;
								count_q  <= count_q - CW'(1);
							end
						end else if (count_q == CW'(QUEUE_DEPTH)) begin
							status_q <= ST_FULL;
							state_q  <= S_HREAD;
						end else begin
							status_q <= ST_DONE;
							state_q  <= (sorted && count_q != '0) ? S_SCAN : S_PUT;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						pos_q   <= idx_m1;
						idx_q   <= count_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else if (scan_end) begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end else begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				S_SHIFT: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (shift_last) begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end else begin
						idx_q <= idx_m1;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_HREAD;
				end
				S_HREAD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			tag_q   <= task_tag;
			burst_q <= burst_time;
			level_q <= priority_level;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign done.valid  = (state_q == S_DONE);
	assign done.status = status_q;
	assign count       = count_q;

endmodule

`default_nettype wire

// File: rtl/policy_ordered_ready_queue.sv
// Top level of the policy-ordered ready queue: policy register, output stage.
// Depends on prq_pkg; instantiates prq_ctrl and prq_ram.
`default_nettype none

// Bounded ready queue of up to QUEUE_DEPTH tasks kept in one slot RAM used as
// a circular buffer, ordered by the policy register (0 FCFS, 1 shortest job
// first, 2 priority, 3 append). Each input transaction is an insert or a
// remove and yields one result with the status, the head task and the
// occupancy. One transaction at a time runs through a sequencer that does all
// work through the RAM's single read port and a shared comparator. A remove
// or a rejected insert just reads the head slot; an appending insert writes
// the task at the tail first; a sorted insert scans from the head for the
// first slot the task goes before, moves the tasks from that slot on up by
// one and writes the task there, or at the tail if none. The input is taken
// again while a finished result still waits in the output register; the
// sequencer stalls only when a second result is ready before the first is
// taken. The policy register takes a write on every cycle and is meant to be
// changed only while the queue is idle.
module policy_ordered_ready_queue #(
	parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
	parameter int LEVEL_COUNT = prq_pkg::LEVEL_COUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [prq_pkg::MODE_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                action,
	input  wire logic [prq_pkg::TAG_W-1:0]           task_tag,
	input  wire logic [prq_pkg::BURST_W-1:0]         burst_time,
	input  wire logic [$clog2(LEVEL_COUNT)-1:0]      priority_level,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [prq_pkg::STATUS_W-1:0]             status_code,
	output logic                                     head_valid,
	output logic [prq_pkg::TAG_W-1:0]                head_tag,
	output logic [prq_pkg::BURST_W-1:0]              head_burst,
	output logic [$clog2(LEVEL_COUNT)-1:0]           head_level,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]         occupancy
);

	import prq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = $clog2(LEVEL_COUNT);
	localparam int EW = TAG_W + BURST_W + LW;

	logic [MODE_W-1:0]   mode_q;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	prq_done_t           done;
	logic                take;
	logic [CW-1:0]       count;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                head_valid_q;
	logic [TAG_W-1:0]    head_tag_q;
	logic [BURST_W-1:0]  head_burst_q;
	logic [LW-1:0]       head_level_q;
	logic [CW-1:0]       occupancy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	prq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.LEVEL_COUNT(LEVEL_COUNT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.task_tag      (task_tag),
		.burst_time    (burst_time),
		.priority_level(priority_level),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.done          (done),
		.take          (take),
		.count         (count)
	);

	prq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// capture the finished transaction once the output register is free
	assign take = done.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q     <= done.status;
			occupancy_q  <= count;
			head_valid_q <= (count != '0);
			// an empty queue reports a zero head
			if (count != '0) begin
				head_tag_q   <= ram_rdata[EW-1 -: TAG_W];
				head_burst_q <= ram_rdata[LW +: BURST_W];
				head_level_q <= ram_rdata[LW-1:0];
			end else begin
				head_tag_q   <= '0;
				head_burst_q <= '0;
				head_level_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status_code = status_q;
	assign head_valid  = head_valid_q;
	assign head_tag    = head_tag_q;
	assign head_burst  = head_burst_q;
	assign head_level  = head_level_q;
	assign occupancy   = occupancy_q;

endmodule

`default_nettype wire
